[hw/rtl/cfs_pkg.sv]
// ----------------------------------------------------------------------------
// cfs_pkg
// Shared constants and types for the circular FIFO with search.
// ----------------------------------------------------------------------------
package cfs_pkg;

    localparam int DEPTH     = 64;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int CAP_W     = 7;
    localparam int DATA_W    = 32;
    localparam int CAP_RESET = 64;

    typedef enum logic [2:0] {
        OP_ENQ    = 3'd0,
        OP_DEQ    = 3'd1,
        OP_PEEK   = 3'd2,
        OP_SEARCH = 3'd3,
        OP_CLEAR  = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_SEARCH
    } state_t;

endpackage

[hw/rtl/cfs_ram.sv]
// ----------------------------------------------------------------------------
// cfs_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
module cfs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[hw/rtl/circular_fifo_with_search_core.sv]
// ----------------------------------------------------------------------------
// circular_fifo_with_search_core
// Circular FIFO of signed 32-bit words with enqueue, dequeue, peek, clear and
// a linear search from the oldest to the newest entry.
// ----------------------------------------------------------------------------
// Enqueue, clear, unused codes and requests on an empty queue give their result
// in the cycle after the request; dequeue and peek pass through S_READ for the RAM read.
// Search examines one entry per cycle, from the oldest, until a match or the last entry.
// One request at a time: a new one is taken only in S_IDLE with the result register
// free or being drained. Reset clears the pointers, the count and the result valid
// flag and sets the capacity to 64; the slot RAM is only read once written.
// ----------------------------------------------------------------------------
module circular_fifo_with_search_core
    import cfs_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    // Request channel.
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [2:0]               operation,
    input  logic signed [DATA_W-1:0] data_value,
    // Result channel.
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [1:0]               status,
    output logic signed [DATA_W-1:0] data_out,
    output logic [ADDR_W-1:0]        found_slot,
    output logic [CNT_W-1:0]         item_count,
    // Capacity register write channel.
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CAP_W-1:0]         capacity
);

    // Advance a slot index, wrapping at the effective capacity.
    function automatic logic [ADDR_W-1:0] advance(input logic [ADDR_W-1:0] idx,
                                                  input logic [CNT_W-1:0]  cap);
        logic [CNT_W-1:0] nxt;
        nxt = CNT_W'(idx) + CNT_W'(1);
        if (nxt >= cap)
        begin
            return '0;
        end
        return nxt[ADDR_W-1:0];
    endfunction

    state_t              state_reg, state_next;
    logic [CAP_W-1:0]    cap_reg, cap_next;
    logic [ADDR_W-1:0]   head_reg, head_next;
    logic [ADDR_W-1:0]   tail_reg, tail_next;
    logic [CNT_W-1:0]    count_reg, count_next;

    // Search walk: cmp_idx_reg is the slot whose word is on the RAM output,
    // cmp_left_reg the number of live entries still to examine, including it.
    logic [ADDR_W-1:0]   cmp_idx_reg, cmp_idx_next;
    logic [CNT_W-1:0]    cmp_left_reg, cmp_left_next;
    logic [DATA_W-1:0]   key_reg, key_next;

    // Output register.
    logic                out_valid_reg, out_valid_next;
    status_t             status_reg, status_next;
    logic [DATA_W-1:0]   data_reg, data_next;
    logic [ADDR_W-1:0]   slot_reg, slot_next;
    logic [CNT_W-1:0]    ocount_reg, ocount_next;

    logic [CNT_W-1:0]    eff_cap;
    logic                in_fire;
    logic                cfg_fire;
    logic                load_out;

    logic                ram_we;
    logic                ram_re;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [DATA_W-1:0]   ram_rdata;

    // A written capacity of zero acts as one, a value above the depth as the depth.
    always_comb
    begin
        if (cap_reg == '0)
        begin
            eff_cap = CNT_W'(1);
        end
        else if (int'(cap_reg) > DEPTH)
        begin
            eff_cap = CNT_W'(DEPTH);
        end
        else
        begin
            eff_cap = CNT_W'(cap_reg);
        end
    end

    // A new request is taken only when the output register is free or being
    // drained, so the result of this request always has a place to land.
    assign cfg_ready = (state_reg == S_IDLE);
    assign in_ready  = (state_reg == S_IDLE) && !cfg_valid && (!out_valid_reg || out_ready);
    assign in_fire   = in_valid && in_ready;
    assign cfg_fire  = cfg_valid && cfg_ready;

    cfs_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .waddr (tail_reg),
        .wdata (data_value),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cap_reg       <= CAP_W'(CAP_RESET);
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            cmp_left_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cap_reg       <= cap_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            cmp_left_reg  <= cmp_left_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_idx_reg <= cmp_idx_next;
        key_reg     <= key_next;
        status_reg  <= status_next;
        data_reg    <= data_next;
        slot_reg    <= slot_next;
        ocount_reg  <= ocount_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        cap_next      = cap_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        count_next    = count_reg;
        cmp_idx_next  = cmp_idx_reg;
        cmp_left_next = cmp_left_reg;
        key_next      = key_reg;
        status_next   = status_reg;
        data_next     = data_reg;
        slot_next     = slot_reg;
        ocount_next   = ocount_reg;
        load_out      = 1'b0;
        ram_we        = 1'b0;
        ram_re        = 1'b0;
        ram_raddr     = head_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (cfg_fire)
                begin
                    // A new capacity empties the queue.
                    cap_next   = capacity;
                    head_next  = '0;
                    tail_next  = '0;
                    count_next = '0;
                end
                else if (in_fire)
                begin
                    load_out    = 1'b1;
                    status_next = ST_OK;
                    data_next   = '0;
                    slot_next   = '0;
                    ocount_next = count_reg;
                    case (op_t'(operation))
                        OP_ENQ:
                        begin
                            if (count_reg >= eff_cap)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                ram_we      = 1'b1;
                                tail_next   = advance(tail_reg, eff_cap);
                                count_next  = count_reg + CNT_W'(1);
                                ocount_next = count_reg + CNT_W'(1);
                            end
                        end
                        OP_DEQ, OP_PEEK:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                // The result waits in S_READ for the RAM word.
                                load_out   = 1'b0;
                                ram_re     = 1'b1;
                                state_next = S_READ;
                                if (op_t'(operation) == OP_DEQ)
                                begin
                                    head_next  = advance(head_reg, eff_cap);
                                    count_next = count_reg - CNT_W'(1);
                                end
                            end
                        end
                        OP_SEARCH:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = ST_NOTFOUND;
                            end
                            else
                            begin
                                load_out      = 1'b0;
                                ram_re        = 1'b1;
                                cmp_idx_next  = head_reg;
                                cmp_left_next = count_reg;
                                key_next      = data_value;
                                state_next    = S_SEARCH;
                            end
                        end
                        OP_CLEAR:
                        begin
                            head_next   = '0;
                            tail_next   = '0;
                            count_next  = '0;
                            ocount_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_READ:
            begin
                load_out    = 1'b1;
                status_next = ST_OK;
                data_next   = ram_rdata;
                slot_next   = '0;
                ocount_next = count_reg;
                state_next  = S_IDLE;
            end
            S_SEARCH:
            begin
                // Keep the next read in flight while the current word is compared.
                ram_re    = 1'b1;
                ram_raddr = advance(cmp_idx_reg, eff_cap);
                if (ram_rdata == key_reg)
                begin
                    load_out    = 1'b1;
                    status_next = ST_OK;
                    data_next   = '0;
                    slot_next   = cmp_idx_reg;
                    ocount_next = count_reg;
                    state_next  = S_IDLE;
                end
                else if (cmp_left_reg == CNT_W'(1))
                begin
                    load_out    = 1'b1;
                    status_next = ST_NOTFOUND;
                    data_next   = '0;
                    slot_next   = '0;
                    ocount_next = count_reg;
                    state_next  = S_IDLE;
                end
                else
                begin
                    cmp_idx_next  = ram_raddr;
                    cmp_left_next = cmp_left_reg - CNT_W'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign data_out   = data_reg;
    assign found_slot = slot_reg;
    assign item_count = ocount_reg;

`ifndef SYNTHESIS
    // The queue never holds more than the effective capacity.
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= eff_cap)
        else $error("held count exceeds capacity");

    // Empty and full queues both have head and tail on the same slot.
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0 || count_reg == eff_cap) |-> (head_reg == tail_reg))
        else $error("head and tail disagree with the held count");

    // A search walk always has at least one live entry left to examine.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SEARCH) |-> (cmp_left_reg != '0))
        else $error("search walk ran past the live entries");

    // A pending result is never overwritten before it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !load_out)
        else $error("result register overwritten while waiting");
`endif

endmodule

[dv/fifo_search_checker.sv]
// ----------------------------------------------------------------------------
// fifo_search_checker
// Watches the request, result and capacity channels of the circular FIFO.
// It keeps its own copy of the queue, works out the result of every accepted
// request and compares each accepted result with the oldest one pending.
// ----------------------------------------------------------------------------
module fifo_search_checker
    import cfs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_ready,
    input  logic [2:0]        operation,
    input  logic [DATA_W-1:0] data_value,
    input  logic              out_valid,
    input  logic              out_ready,
    input  logic [1:0]        status,
    input  logic [DATA_W-1:0] data_out,
    input  logic [ADDR_W-1:0] found_slot,
    input  logic [CNT_W-1:0]  item_count,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic [CAP_W-1:0]  capacity,
    output int                fail_count,
    output int                outstanding
);

    typedef struct {
        status_t           st;
        logic [DATA_W-1:0] data;
        logic [ADDR_W-1:0] slot;
        logic [CNT_W-1:0]  count;
    } fifo_result_t;

    logic [DATA_W-1:0] mirror_mem [DEPTH];
    int                mirror_head;
    int                mirror_tail;
    int                mirror_count;
    logic [CAP_W-1:0]  cap_written;
    fifo_result_t      awaited_results [$];
    int                result_index;

    function automatic int wrap_next(input int idx, input int cap);
        return (idx + 1 >= cap) ? 0 : idx + 1;
    endfunction

    // Applies one request to the mirrored queue and returns its result.
    function automatic fifo_result_t next_fifo_result(input logic [2:0] op,
                                                      input logic [DATA_W-1:0] val);
        fifo_result_t r;
        int           cap;
        int           idx;
        bit           hit;
        cap = (cap_written == 0) ? 1 : ((cap_written > DEPTH) ? DEPTH : int'(cap_written));
        r.st   = ST_OK;
        r.data = '0;
        r.slot = '0;
        case (op)
            OP_ENQ:
            begin
                if (mirror_count >= cap)
                begin
                    r.st = ST_FULL;
                end
                else
                begin
                    mirror_mem[mirror_tail] = val;
                    mirror_tail = wrap_next(mirror_tail, cap);
                    mirror_count++;
                end
            end
            OP_DEQ:
            begin
                if (mirror_count == 0)
                begin
                    r.st = ST_EMPTY;
                end
                else
                begin
                    r.data = mirror_mem[mirror_head];
                    mirror_head = wrap_next(mirror_head, cap);
                    mirror_count--;
                end
            end
            OP_PEEK:
            begin
                if (mirror_count == 0)
                    r.st = ST_EMPTY;
                else
                    r.data = mirror_mem[mirror_head];
            end
            OP_SEARCH:
            begin
                hit = 1'b0;
                idx = mirror_head;
                for (int i = 0; i < mirror_count && !hit; i++)
                begin
                    if (mirror_mem[idx] == val)
                    begin
                        hit = 1'b1;
                        r.slot = idx[ADDR_W-1:0];
                    end
                    else
                    begin
                        idx = wrap_next(idx, cap);
                    end
                end
                if (!hit)
                    r.st = ST_NOTFOUND;
            end
            OP_CLEAR:
            begin
                mirror_head  = 0;
                mirror_tail  = 0;
                mirror_count = 0;
            end
            default:
            begin
            end
        endcase
        r.count = CNT_W'(mirror_count);
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input logic [DATA_W-1:0] want,
                                 input logic [DATA_W-1:0] got);
        fail_count++;
        if (fail_count <= 10)
            $display("checker: result %0d, %s: expected 0x%0h, got 0x%0h",
                     result_index, what, want, got);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        fifo_result_t want;
        if (!rst_n)
        begin
            mirror_head  = 0;
            mirror_tail  = 0;
            mirror_count = 0;
            cap_written  = CAP_W'(CAP_RESET);
            awaited_results.delete();
            result_index = 0;
            fail_count   = 0;
            outstanding <= 0;
        end
        else
        begin
            // A capacity write empties the queue.
            if (cfg_valid && cfg_ready)
            begin
                cap_written  = capacity;
                mirror_head  = 0;
                mirror_tail  = 0;
                mirror_count = 0;
            end
            if (in_valid && in_ready)
                awaited_results.push_back(next_fifo_result(operation, data_value));
            if (out_valid && out_ready)
            begin
                if (awaited_results.size() == 0)
                begin
                    flag_mismatch("status with no request pending", '0, DATA_W'(status));
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (status !== want.st)
                        flag_mismatch("status", DATA_W'(want.st), DATA_W'(status));
                    if (data_out !== want.data)
                        flag_mismatch("data_out", want.data, data_out);
                    if (found_slot !== want.slot)
                        flag_mismatch("found_slot", DATA_W'(want.slot), DATA_W'(found_slot));
                    if (item_count !== want.count)
                        flag_mismatch("item_count", DATA_W'(want.count), DATA_W'(item_count));
                end
                result_index++;
            end
            outstanding <= awaited_results.size();
        end
    end

endmodule

[dv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Drives the circular FIFO with search through a directed opening and a long
// run of random requests over several capacity settings, with random idling
// on both channels; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module testbench
    import cfs_pkg::*;
();

    // Operation codes the block leaves unused; they must change nothing.
    localparam logic [2:0] OP_UNUSED_LO  = 3'd5;
    localparam logic [2:0] OP_UNUSED_MID = 3'd6;
    localparam logic [2:0] OP_UNUSED_HI  = 3'd7;
    localparam int         PHASES        = 11;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic [2:0]        operation;
    logic [DATA_W-1:0] data_value;
    logic              out_valid;
    logic              out_ready;
    logic [1:0]        status;
    logic [DATA_W-1:0] data_out;
    logic [ADDR_W-1:0] found_slot;
    logic [CNT_W-1:0]  item_count;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [CAP_W-1:0]  capacity;
    int                fail_count;
    int                outstanding;

    // While quiet is set neither side idles.
    bit                quiet;
    logic [DATA_W-1:0] value_pool [8];

    circular_fifo_with_search_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .operation  (operation),
        .data_value (data_value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .data_out   (data_out),
        .found_slot (found_slot),
        .item_count (item_count),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .capacity   (capacity)
    );

    fifo_search_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .operation   (operation),
        .data_value  (data_value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .data_out    (data_out),
        .found_slot  (found_slot),
        .item_count  (item_count),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .capacity    (capacity),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // The result side stalls with a chance of roughly 23 percent at each edge.
    always @(posedge clk)
        out_ready <= quiet || ($urandom_range(99) >= 23);

    // Presents one request and returns at the edge that accepts it. The valid
    // stays high on return, so a back-to-back request needs no second write to
    // in_valid within the same time step; it is only lowered for a gap.
    task automatic send_req(input logic [2:0] op, input logic [DATA_W-1:0] val);
        if (!quiet && $urandom_range(99) < 23)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid   <= 1'b1;
        operation  <= op;
        data_value <= val;
        do @(posedge clk); while (!in_ready);
    endtask

    // Stops sending and waits until every request has its result. The count
    // from the checker is registered, so the task always waits for an edge first.
    task automatic wait_idle();
        in_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    // Capacity is only ever written with the block idle.
    task automatic write_capacity(input logic [CAP_W-1:0] value);
        wait_idle();
        cfg_valid <= 1'b1;
        capacity  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Filling phases lean hard on enqueue so that the queue reaches full;
    // draining phases lean on dequeue and clear so that it runs empty.
    function automatic logic [2:0] pick_op(input bit filling);
        int r;
        r = $urandom_range(99);
        if (filling)
        begin
            if (r < 72) return OP_ENQ;
            if (r < 77) return OP_DEQ;
            if (r < 82) return OP_PEEK;
            if (r < 98) return OP_SEARCH;
            return 3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
        end
        if (r < 25) return OP_ENQ;
        if (r < 55) return OP_DEQ;
        if (r < 65) return OP_PEEK;
        if (r < 88) return OP_SEARCH;
        if (r < 95) return OP_CLEAR;
        return 3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
    endfunction

    // Most values come from a small pool, so searches hit and duplicates make
    // the first match matter; the rest are fully random or extreme.
    function automatic logic [DATA_W-1:0] pick_value();
        int r;
        r = $urandom_range(99);
        if (r < 60) return value_pool[$urandom_range(7)];
        if (r < 90) return $urandom;
        case ($urandom_range(3))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    initial
    begin
        logic [CAP_W-1:0] phase_cap   [PHASES];
        int               phase_items [PHASES];
        int               phase_block [PHASES];

        rst_n      = 1'b0;
        in_valid   = 1'b0;
        operation  = OP_ENQ;
        data_value = '0;
        out_ready  = 1'b0;
        cfg_valid  = 1'b0;
        capacity   = CAP_W'(CAP_RESET);
        quiet      = 1'b0;

        // Capacity settings for the random part: tiny sizes wrap constantly,
        // zero must act as one, and values past the depth must act as the depth.
        phase_cap   = '{7'd2, 7'd3, 7'd64, 7'd1, 7'd5, 7'd127, 7'd65, 7'd8, 7'd0,
                        7'd64, 7'd0};
        phase_items = '{80, 80, 200, 60, 80, 200, 120, 80, 60, 160, 80};
        phase_block = '{8, 8, 100, 4, 8, 100, 100, 8, 4, 100, 16};
        phase_cap[PHASES-1] = CAP_W'($urandom_range(127));

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed opening at the reset capacity: operations on an empty
        // queue, the extreme data values, a search with a duplicate, a miss,
        // the unused codes and a clear.
        send_req(OP_PEEK,   32'h0000_0000);
        send_req(OP_DEQ,    32'h0000_0000);
        send_req(OP_SEARCH, 32'h0000_0000);
        send_req(OP_ENQ,    32'h8000_0000);
        send_req(OP_ENQ,    32'h7FFF_FFFF);
        send_req(OP_ENQ,    32'hFFFF_FFFF);
        send_req(OP_ENQ,    32'h7FFF_FFFF);
        send_req(OP_SEARCH, 32'h7FFF_FFFF);
        send_req(OP_SEARCH, 32'h0000_0000);
        send_req(OP_PEEK,   32'h0000_0000);
        send_req(OP_DEQ,    32'h0000_0000);
        send_req(OP_UNUSED_LO,  32'hFFFF_FFFF);
        send_req(OP_UNUSED_MID, 32'h0000_0000);
        send_req(OP_UNUSED_HI,  32'hFFFF_FFFF);
        send_req(OP_CLEAR,  32'h0000_0000);
        send_req(OP_DEQ,    32'h0000_0000);

        // A written zero acts as one slot: the second enqueue is refused and
        // the tail wraps straight back onto slot zero.
        write_capacity(7'd0);
        send_req(OP_ENQ,    32'h1234_5678);
        send_req(OP_ENQ,    32'h0000_0000);
        send_req(OP_DEQ,    32'h0000_0000);
        send_req(OP_ENQ,    32'hA5A5_A5A5);
        send_req(OP_SEARCH, 32'hA5A5_A5A5);
        send_req(OP_SEARCH, 32'h1234_5678);

        for (int p = 0; p < PHASES; p++)
        begin
            foreach (value_pool[k])
                value_pool[k] = $urandom;
            write_capacity(phase_cap[p]);
            // The first large fill runs with no idling on either side.
            quiet = (p == 2);
            for (int i = 0; i < phase_items[p]; i++)
            begin
                // Once mid-phase the sender holds off until the queue of
                // pending results has fully drained.
                if (p == 4 && i == 40)
                    wait_idle();
                send_req(pick_op(((i / phase_block[p]) % 2) == 0), pick_value());
            end
            quiet = 1'b0;
        end

        wait_idle();
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

    // Guard against a hang: far beyond the slowest correct run.
    initial
    begin
        #10_000_000;
        $display("testbench: done, errors");
        $finish;
    end

endmodule
